### rtl/core/utf8d_pkg.sv
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned PartWidth = 18;
  localparam int unsigned LenWidth  = 3;

  // Continuation bytes carry the pattern 10xxxxxx in their top two bits.
  localparam logic [1:0] ContTag = 2'b10;

  localparam logic [LenWidth-1:0] SeqLen1 = 3'd1;
  localparam logic [LenWidth-1:0] SeqLen2 = 3'd2;
  localparam logic [LenWidth-1:0] SeqLen3 = 3'd3;
  localparam logic [LenWidth-1:0] SeqLen4 = 3'd4;

  typedef struct packed {
    logic [1:0]           pending;
    logic [PartWidth-1:0] partial;
    logic [LenWidth-1:0]  total;
  } seq_state_t;

  typedef struct packed {
    logic                valid;
    logic [CpWidth-1:0]  code_point;
    logic                bad;
    logic [LenWidth-1:0] seq_bytes;
  } dec_result_t;

endpackage

### rtl/core/utf8d_decode.sv
`timescale 1ns / 1ps

module utf8d_decode
  import utf8d_pkg::*;
#(
  parameter bit FourByte = 1'b1
) (
  input  logic [7:0]  byte_i,
  input  seq_state_t  state_i,
  output seq_state_t  state_o,
  output dec_result_t result_o
);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.pending != 2'd0) begin
      if (byte_i[7:6] != ContTag) begin
        // A broken sequence reports the length it was expected to have.
        result_o.valid     = 1'b1;
        result_o.bad       = 1'b1;
        result_o.seq_bytes = state_i.total;
        state_o            = '0;
      end else if (state_i.pending == 2'd1) begin
        result_o.valid      = 1'b1;
        result_o.code_point = {state_i.partial[CpWidth-7:0], byte_i[5:0]};
        result_o.seq_bytes  = state_i.total;
        state_o             = '0;
      end else begin
        state_o.partial = {state_i.partial[PartWidth-7:0], byte_i[5:0]};
        state_o.pending = state_i.pending - 2'd1;
      end
    end else if (!byte_i[7]) begin
      result_o.valid      = 1'b1;
      result_o.code_point = {{(CpWidth-8){1'b0}}, byte_i};
      result_o.seq_bytes  = SeqLen1;
    end else if (!byte_i[6]) begin
      result_o.valid     = 1'b1;
      result_o.bad       = 1'b1;
      result_o.seq_bytes = SeqLen1;
    end else if (!byte_i[5]) begin
      state_o.partial = {{(PartWidth-5){1'b0}}, byte_i[4:0]};
      state_o.total   = SeqLen2;
      state_o.pending = 2'd1;
    end else if (!byte_i[4] || !FourByte) begin
      state_o.partial = {{(PartWidth-4){1'b0}}, byte_i[3:0]};
      state_o.total   = SeqLen3;
      state_o.pending = 2'd2;
    end else begin
      state_o.partial = {{(PartWidth-3){1'b0}}, byte_i[2:0]};
      state_o.total   = SeqLen4;
      state_o.pending = 2'd3;
    end
  end

endmodule

### rtl/core/utf8_stream_decoder.sv
`timescale 1ns / 1ps

// UTF-8 byte stream decoder. One byte is accepted per cycle; each byte passes
// through an input register, is decoded against the open-sequence state, and
// a finished code point is then registered in the output register once the
// held byte advances. Lead bytes and inner continuation bytes produce no
// output transaction; ASCII bytes, stray continuations, final continuations and
// broken sequences produce exactly one. Throughput is one byte per cycle as long
// as the output side takes results; the only stall comes from a full output
// register. MAX_SEQ_BYTES of 3 folds all leads from 0xE0 up into 3-byte forms.
module utf8_stream_decoder
  import utf8d_pkg::*;
#(
  parameter int unsigned MAX_SEQ_BYTES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CpWidth-1:0]  code_point_o,
  output logic                bad_sequence_o,
  output logic [LenWidth-1:0] seq_bytes_o
);

  localparam bit FourByte = (MAX_SEQ_BYTES >= 4);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  seq_state_t  state_q, state_d;
  dec_result_t dec_res;
  dec_result_t out_q;
  logic        advance;

  utf8d_decode #(
    .FourByte(FourByte)
  ) u_decode (
    .byte_i  (in_byte_q),
    .state_i (state_q),
    .state_o (state_d),
    .result_o(dec_res)
  );

  // The held byte moves on whenever the output register is free or drains now.
  assign advance    = in_valid_q && (!out_q.valid || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
      out_q      <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_q.valid <= dec_res.valid;
      end else if (!out_stall_i) begin
        out_q.valid <= 1'b0;
      end
      if (advance && dec_res.valid) begin
        out_q.code_point <= dec_res.code_point;
        out_q.bad        <= dec_res.bad;
        out_q.seq_bytes  <= dec_res.seq_bytes;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  assign out_valid_o    = out_q.valid;
  assign code_point_o   = out_q.code_point;
  assign bad_sequence_o = out_q.bad;
  assign seq_bytes_o    = out_q.seq_bytes;

  // Sequence state only changes when a byte is actually consumed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("sequence state changed without a consumed byte");

  // An open sequence always has a known length, and a closed one has none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.pending == 2'd0) == (state_q.total == 3'd0))
    else $error("pending count and sequence length disagree");

  // Error results carry no code point, and single-byte results are ASCII.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bad_sequence_o ? (code_point_o == '0)
                     : ((seq_bytes_o != SeqLen1) || (code_point_o[CpWidth-1:7] == '0))))
    else $error("result payload inconsistent with its kind");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import utf8d_pkg::*;

  localparam int unsigned MaxSeqBytes = 4;
  localparam int RandomItems = 1100;
  localparam int HoldCycles  = 60;
  localparam int DrainCycles = 20;

  typedef struct packed {
    logic [CpWidth-1:0]  cp;
    logic                bad;
    logic [LenWidth-1:0] len;
  } point_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          in_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CpWidth-1:0]  code_point_o;
  logic                bad_sequence_o;
  logic [LenWidth-1:0] seq_bytes_o;

  logic [7:0] byte_q[$];
  point_t     point_q[$];

  // Decoder state mirrored on the accepted byte stream.
  logic [1:0]          dec_pending = '0;
  logic [PartWidth-1:0] dec_part   = '0;
  logic [LenWidth-1:0]  dec_total  = '0;

  int bytes_sent  = 0;
  int bytes_taken = 0;
  int points_seen = 0;
  int bad_seen    = 0;
  int error_count = 0;
  int total_bytes = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  utf8_stream_decoder #(
    .MAX_SEQ_BYTES(MaxSeqBytes)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .bad_sequence_o(bad_sequence_o),
    .seq_bytes_o   (seq_bytes_o)
  );

  always #2 clk_i = ~clk_i;

  // Stall mix: sender light / receiver heavy, then swapped, then one output hold-off.
  function automatic int mix_phase();
    if (bytes_sent < total_bytes / 3) return 0;
    if (bytes_sent < (2 * total_bytes) / 3) return 1;
    return 2;
  endfunction

  task automatic clear_seq();
    dec_pending = '0;
    dec_part    = '0;
    dec_total   = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    point_t p;
    logic [PartWidth+5:0] wide;
    p = '0;
    wide = {dec_part, b[5:0]};
    if (dec_pending != 2'd0) begin
      if (b[7:6] != ContTag) begin
        p.bad = 1'b1;
        p.len = dec_total;
        clear_seq();
        point_q.push_back(p);
      end else if (dec_pending == 2'd1) begin
        p.cp  = wide[CpWidth-1:0];
        p.len = dec_total;
        clear_seq();
        point_q.push_back(p);
      end else begin
        dec_part    = wide[PartWidth-1:0];
        dec_pending = dec_pending - 2'd1;
      end
    end else if (b < 8'h80) begin
      p.cp  = CpWidth'(b);
      p.len = SeqLen1;
      point_q.push_back(p);
    end else if (b < 8'hC0) begin
      // A continuation byte with no open sequence is flagged on its own.
      p.bad = 1'b1;
      p.len = SeqLen1;
      point_q.push_back(p);
    end else begin
      if (b < 8'hE0) begin
        dec_part  = PartWidth'(b[4:0]);
        dec_total = SeqLen2;
      end else if (b < 8'hF0 || MaxSeqBytes < 4) begin
        dec_part  = PartWidth'(b[3:0]);
        dec_total = SeqLen3;
      end else begin
        dec_part  = PartWidth'(b[2:0]);
        dec_total = SeqLen4;
      end
      dec_pending = 2'(dec_total - 3'd1);
    end
  endtask

  function automatic logic [7:0] lead_byte(input int n, input logic [7:0] r);
    case (n)
      1:       return {1'b0, r[6:0]};
      2:       return {3'b110, r[4:0]};
      3:       return {4'b1110, r[3:0]};
      default: return {4'b1111, r[3:0]};
    endcase
  endfunction

  // Driver: a new transaction is offered only once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    int idle_pct;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'h00;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_byte_i);
        bytes_taken++;
      end
      case (mix_phase())
        0:       idle_pct = 16;
        1:       idle_pct = 65;
        default: idle_pct = 0;
      endcase
      if (!in_valid_i || !in_stall_o) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_byte_i  <= byte_q.pop_front();
          in_valid_i <= 1'b1;
          bytes_sent++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and output-side stall generator.
  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    int stall_pct;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        points_seen++;
        if (bad_sequence_o) bad_seen++;
        if (point_q.size() == 0) begin
          $error("result with nothing expected: code_point=%0h bad_sequence=%0b seq_bytes=%0d",
                 code_point_o, bad_sequence_o, seq_bytes_o);
          error_count++;
        end else begin
          want = point_q.pop_front();
          if (code_point_o !== want.cp) begin
            $error("code_point: expected %0h, got %0h", want.cp, code_point_o);
            error_count++;
          end
          if (bad_sequence_o !== want.bad) begin
            $error("bad_sequence: expected %0b, got %0b", want.bad, bad_sequence_o);
            error_count++;
          end
          if (seq_bytes_o !== want.len) begin
            $error("seq_bytes: expected %0d, got %0d", want.len, seq_bytes_o);
            error_count++;
          end
        end
      end
      case (mix_phase())
        0:       stall_pct = 65;
        1:       stall_pct = 16;
        default: stall_pct = 0;
      endcase
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (!hold_done && mix_phase() == 2) begin
        // Long hold-off while the sender keeps streaming, so the input backs up.
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int nlen;
    int ncont;
    int kind;
    logic [7:0] r;

    // Extremes of each sequence length, stray continuations, F8-FF leads,
    // a sequence broken by ASCII and one broken by a new lead.
    byte_q = '{8'h00, 8'h7F, 8'h80, 8'hBF,
               8'hC0, 8'h80, 8'hDF, 8'hBF,
               8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF,
               8'hF0, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hBF, 8'hBF, 8'hBF,
               8'hC2, 8'h41, 8'hE2, 8'h82, 8'hF5};
    total_bytes = byte_q.size() + RandomItems;

    while (byte_q.size() < total_bytes) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        nlen = $urandom_range(MaxSeqBytes, 1);
        r = 8'($urandom_range(255));
        byte_q.push_back(lead_byte(nlen, r));
        for (int i = 1; i < nlen; i++) begin
          r = 8'($urandom_range(255));
          byte_q.push_back({ContTag, r[5:0]});
        end
      end else if (kind < 85) begin
        nlen = $urandom_range(MaxSeqBytes, 2);
        r = 8'($urandom_range(255));
        byte_q.push_back(lead_byte(nlen, r));
        ncont = $urandom_range(nlen - 2, 0);
        for (int i = 0; i < ncont; i++) begin
          r = 8'($urandom_range(255));
          byte_q.push_back({ContTag, r[5:0]});
        end
        do r = 8'($urandom_range(255)); while (r[7:6] == ContTag);
        byte_q.push_back(r);
      end else begin
        byte_q.push_back(8'($urandom_range(255)));
      end
    end
    total_bytes = byte_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (byte_q.size() == 0 && bytes_taken == bytes_sent);
    wait (point_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d bytes and %0d results (%0d flagged bad) under three stall mixes",
             bytes_taken, points_seen, bad_seen);
    $display("plus a %0d-cycle output hold-off with the input still streaming.", HoldCycles);
    if (error_count == 0 && point_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d bytes accepted and %0d results pending.",
             bytes_taken, point_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_decode.sv
rtl/core/utf8_stream_decoder.sv
verif/tb_top.sv
